### hdl/ecpr_pkg.sv
// ----------------------------------------------------------------------------
// ecpr_pkg
// Shared types and constants of the enhanced clock page replacer.
// ----------------------------------------------------------------------------
package ecpr_pkg;

  localparam int unsigned NumFramesDef = 64;
  localparam int unsigned PageBits     = 20;

  typedef enum logic [1:0] {
    ACT_MAP    = 2'd0,
    ACT_REF    = 2'd1,
    ACT_VICTIM = 2'd2,
    ACT_RSVD   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [PageBits-1:0] page_number;
    logic                is_write;
    logic                reinsert;
  } item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [PageBits-1:0] victim_page;
  } result_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_NEW,
    OP_REF,
    OP_DT_RD,
    OP_DT_LAT,
    OP_DT_WR,
    OP_AP_RD,
    OP_AP_WR1,
    OP_AP_WR2,
    OP_W_INIT,
    OP_W_RD,
    OP_W_CHK,
    OP_EVICT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    give;        // load the result register and the done strobe
    status_e status;
    logic    give_victim; // result carries the evicted page
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       reinsert;
    logic       hit;
    logic       scan_last;
    logic       full;
    logic       empty;
    logic       cur_head;
    logic       cur_clean;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SC_RD,
    S_SC_CMP,
    S_NEW,
    S_REF,
    S_DT_RD,
    S_DT_LAT,
    S_DT_WR,
    S_AP_RD,
    S_AP_WR1,
    S_AP_WR2,
    S_W_RD,
    S_W_CHK,
    S_EVICT,
    S_RESULT
  } state_e;

endpackage

### hdl/ecpr_ctrl.sv
// ----------------------------------------------------------------------------
// ecpr_ctrl
// Sequencer: walks each item through scan, detach, append and sweep steps.
// ----------------------------------------------------------------------------
module ecpr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ecpr_pkg::dp_stat_t stat_i,
  output ecpr_pkg::dp_cmd_t  cmd_o
);

  ecpr_pkg::state_e  state_q, state_d;
  ecpr_pkg::status_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecpr_pkg::S_IDLE;
      res_q   <= ecpr_pkg::STAT_DONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      ecpr_pkg::S_IDLE: begin
        if (start) begin
          state_d = ecpr_pkg::S_DISPATCH;
        end
      end
      ecpr_pkg::S_DISPATCH: begin
        res_d = ecpr_pkg::STAT_DONE;
        if (stat_i.action == ecpr_pkg::ACT_MAP || stat_i.action == ecpr_pkg::ACT_REF) begin
          state_d = ecpr_pkg::S_SC_RD;
        end else if (stat_i.action == ecpr_pkg::ACT_VICTIM) begin
          if (stat_i.empty) begin
            res_d   = ecpr_pkg::STAT_EMPTY;
            state_d = ecpr_pkg::S_RESULT;
          end else begin
            state_d = ecpr_pkg::S_W_RD;
          end
        end else begin
          state_d = ecpr_pkg::S_RESULT;
        end
      end
      ecpr_pkg::S_SC_RD: state_d = ecpr_pkg::S_SC_CMP;
      ecpr_pkg::S_SC_CMP: begin
        if (stat_i.hit) begin
          if (stat_i.action == ecpr_pkg::ACT_REF) begin
            state_d = ecpr_pkg::S_REF;
          end else if (stat_i.reinsert) begin
            state_d = ecpr_pkg::S_DT_RD;
          end else begin
            state_d = ecpr_pkg::S_RESULT;
          end
        end else if (stat_i.scan_last) begin
          if (stat_i.action == ecpr_pkg::ACT_REF) begin
            res_d   = ecpr_pkg::STAT_MISS;
            state_d = ecpr_pkg::S_RESULT;
          end else if (stat_i.full) begin
            res_d   = ecpr_pkg::STAT_FULL;
            state_d = ecpr_pkg::S_RESULT;
          end else begin
            state_d = ecpr_pkg::S_NEW;
          end
        end else begin
          state_d = ecpr_pkg::S_SC_RD;
        end
      end
      ecpr_pkg::S_NEW:    state_d = ecpr_pkg::S_AP_RD;
      ecpr_pkg::S_REF:    state_d = ecpr_pkg::S_RESULT;
      ecpr_pkg::S_DT_RD:  state_d = ecpr_pkg::S_DT_LAT;
      ecpr_pkg::S_DT_LAT: state_d = ecpr_pkg::S_DT_WR;
      ecpr_pkg::S_DT_WR: begin
        state_d = (stat_i.action == ecpr_pkg::ACT_VICTIM) ? ecpr_pkg::S_EVICT
                                                          : ecpr_pkg::S_AP_RD;
      end
      ecpr_pkg::S_AP_RD:  state_d = ecpr_pkg::S_AP_WR1;
      ecpr_pkg::S_AP_WR1: state_d = ecpr_pkg::S_AP_WR2;
      ecpr_pkg::S_AP_WR2: state_d = ecpr_pkg::S_RESULT;
      ecpr_pkg::S_W_RD:   state_d = ecpr_pkg::S_W_CHK;
      ecpr_pkg::S_W_CHK: begin
        if (!stat_i.cur_head && stat_i.cur_clean) begin
          state_d = ecpr_pkg::S_DT_RD;
        end else begin
          state_d = ecpr_pkg::S_W_RD;
        end
      end
      ecpr_pkg::S_EVICT:  state_d = ecpr_pkg::S_RESULT;
      ecpr_pkg::S_RESULT: state_d = ecpr_pkg::S_IDLE;
      default:            state_d = ecpr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.op          = ecpr_pkg::OP_NONE;
    cmd_o.status      = res_q;
    cmd_o.give_victim = (stat_i.action == ecpr_pkg::ACT_VICTIM) &&
                        (res_q == ecpr_pkg::STAT_DONE);
    unique case (state_q)
      ecpr_pkg::S_IDLE:     cmd_o.op = start ? ecpr_pkg::OP_LOAD : ecpr_pkg::OP_NONE;
      ecpr_pkg::S_DISPATCH: cmd_o.op = ecpr_pkg::OP_W_INIT;
      ecpr_pkg::S_SC_RD:    cmd_o.op = ecpr_pkg::OP_SCAN_RD;
      ecpr_pkg::S_SC_CMP:   cmd_o.op = ecpr_pkg::OP_SCAN_CMP;
      ecpr_pkg::S_NEW:      cmd_o.op = ecpr_pkg::OP_NEW;
      ecpr_pkg::S_REF:      cmd_o.op = ecpr_pkg::OP_REF;
      ecpr_pkg::S_DT_RD:    cmd_o.op = ecpr_pkg::OP_DT_RD;
      ecpr_pkg::S_DT_LAT:   cmd_o.op = ecpr_pkg::OP_DT_LAT;
      ecpr_pkg::S_DT_WR:    cmd_o.op = ecpr_pkg::OP_DT_WR;
      ecpr_pkg::S_AP_RD:    cmd_o.op = ecpr_pkg::OP_AP_RD;
      ecpr_pkg::S_AP_WR1:   cmd_o.op = ecpr_pkg::OP_AP_WR1;
      ecpr_pkg::S_AP_WR2:   cmd_o.op = ecpr_pkg::OP_AP_WR2;
      ecpr_pkg::S_W_RD:     cmd_o.op = ecpr_pkg::OP_W_RD;
      ecpr_pkg::S_W_CHK:    cmd_o.op = ecpr_pkg::OP_W_CHK;
      ecpr_pkg::S_EVICT:    cmd_o.op = ecpr_pkg::OP_EVICT;
      ecpr_pkg::S_RESULT:   cmd_o.give = 1'b1;
      default:              cmd_o.op = ecpr_pkg::OP_NONE;
    endcase
  end

  assign busy = (state_q != ecpr_pkg::S_IDLE);

endmodule

### hdl/ecpr_dp.sv
// ----------------------------------------------------------------------------
// ecpr_dp
// Datapath: tag store, ring link stores, marks, hand and result register.
// ----------------------------------------------------------------------------
module ecpr_dp #(
  parameter int unsigned NUM_FRAMES = ecpr_pkg::NumFramesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecpr_pkg::item_t    item_i,
  input  ecpr_pkg::dp_cmd_t  cmd_i,
  output ecpr_pkg::dp_stat_t stat_o,
  output ecpr_pkg::result_t  result_o,
  output logic               done_o
);

  localparam int unsigned IdxW  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned SlotW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [IdxW-1:0]  Head     = IdxW'(NUM_FRAMES);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_FRAMES - 1);

  // stores
  logic [ecpr_pkg::PageBits-1:0] tag_mem [NUM_FRAMES];
  logic [IdxW-1:0]               nxt_mem [NUM_FRAMES];
  logic [IdxW-1:0]               prv_mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]         acc_q, dirty_q, used_q;

  logic [IdxW-1:0] head_nxt_q, head_prv_q, hand_q, count_q;
  logic [IdxW-1:0] p_q, n_q, prev_q;
  logic [SlotW-1:0] scan_q, slot_q, free_q;
  logic             free_v_q;
  ecpr_pkg::item_t  item_q;
  logic [ecpr_pkg::PageBits-1:0] tag_rd_q, victim_q;
  logic [IdxW-1:0] nxt_mem_rd_q, prv_mem_rd_q;
  logic            nxt_head_sel_q, prv_head_sel_q;
  ecpr_pkg::result_t res_q;
  logic            done_q;

  logic [IdxW-1:0]  nxt_ra, prv_ra, nxt_wa, prv_wa, nxt_wd, prv_wd;
  logic             nxt_we, prv_we;
  logic [SlotW-1:0] tag_ra;
  logic [IdxW-1:0]  nxt_rd, prv_rd, slot_ext;
  logic [SlotW-1:0] cur_slot;
  logic             hit;

  assign slot_ext = IdxW'(slot_q);
  assign nxt_rd   = nxt_head_sel_q ? head_nxt_q : nxt_mem_rd_q;
  assign prv_rd   = prv_head_sel_q ? head_prv_q : prv_mem_rd_q;
  assign cur_slot = nxt_rd[SlotW-1:0];
  assign hit      = used_q[scan_q] && (tag_rd_q == item_q.page_number);

  always_comb begin
    nxt_ra = Head;
    prv_ra = Head;
    tag_ra = slot_q;
    nxt_we = 1'b0;
    prv_we = 1'b0;
    nxt_wa = Head;
    prv_wa = Head;
    nxt_wd = Head;
    prv_wd = Head;
    case (cmd_i.op)
      ecpr_pkg::OP_SCAN_RD: tag_ra = scan_q;
      ecpr_pkg::OP_DT_RD: begin
        nxt_ra = slot_ext;
        prv_ra = slot_ext;
      end
      ecpr_pkg::OP_W_RD: nxt_ra = prev_q;
      ecpr_pkg::OP_DT_WR: begin
        nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = n_q;
        prv_we = 1'b1; prv_wa = n_q; prv_wd = p_q;
      end
      ecpr_pkg::OP_AP_WR1: begin
        nxt_we = 1'b1; nxt_wa = prv_rd;   nxt_wd = slot_ext;
        prv_we = 1'b1; prv_wa = slot_ext; prv_wd = prv_rd;
      end
      ecpr_pkg::OP_AP_WR2: begin
        nxt_we = 1'b1; nxt_wa = slot_ext; nxt_wd = Head;
        prv_we = 1'b1; prv_wa = Head;     prv_wd = slot_ext;
      end
      default: ;
    endcase
  end

  // memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (nxt_we && nxt_wa != Head) begin
      nxt_mem[nxt_wa[SlotW-1:0]] <= nxt_wd;
    end
    if (prv_we && prv_wa != Head) begin
      prv_mem[prv_wa[SlotW-1:0]] <= prv_wd;
    end
    if (cmd_i.op == ecpr_pkg::OP_NEW) begin
      tag_mem[free_q] <= item_q.page_number;
    end
    nxt_mem_rd_q   <= nxt_mem[nxt_ra[SlotW-1:0]];
    prv_mem_rd_q   <= prv_mem[prv_ra[SlotW-1:0]];
    nxt_head_sel_q <= (nxt_ra == Head);
    prv_head_sel_q <= (prv_ra == Head);
    tag_rd_q       <= tag_mem[tag_ra];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ecpr_pkg::OP_LOAD:   item_q <= item_i;
      ecpr_pkg::OP_DT_LAT: begin
        p_q      <= prv_rd;
        n_q      <= nxt_rd;
        victim_q <= tag_rd_q;
      end
      default: ;
    endcase
    if (cmd_i.give) begin
      res_q.status      <= cmd_i.status;
      res_q.victim_page <= cmd_i.give_victim ? victim_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      dirty_q    <= '0;
      used_q     <= '0;
      head_nxt_q <= Head;
      head_prv_q <= Head;
      hand_q     <= Head;
      count_q    <= '0;
      prev_q     <= Head;
      scan_q     <= '0;
      slot_q     <= '0;
      free_q     <= '0;
      free_v_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.give;
      if (nxt_we && nxt_wa == Head) begin
        head_nxt_q <= nxt_wd;
      end
      if (prv_we && prv_wa == Head) begin
        head_prv_q <= prv_wd;
      end
      case (cmd_i.op)
        ecpr_pkg::OP_LOAD: begin
          scan_q   <= '0;
          free_v_q <= 1'b0;
        end
        ecpr_pkg::OP_SCAN_CMP: begin
          if (hit) begin
            slot_q <= scan_q;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
          if (!used_q[scan_q] && !free_v_q) begin
            free_q   <= scan_q;
            free_v_q <= 1'b1;
          end
        end
        ecpr_pkg::OP_NEW: begin
          slot_q          <= free_q;
          used_q[free_q]  <= 1'b1;
          acc_q[free_q]   <= 1'b0;
          dirty_q[free_q] <= 1'b0;
          count_q         <= count_q + 1'b1;
        end
        ecpr_pkg::OP_REF: begin
          acc_q[slot_q] <= 1'b1;
          if (item_q.is_write) begin
            dirty_q[slot_q] <= 1'b1;
          end
        end
        ecpr_pkg::OP_DT_WR: begin
          if (hand_q == slot_ext) begin
            hand_q <= p_q;
          end
        end
        ecpr_pkg::OP_W_INIT: prev_q <= hand_q;
        ecpr_pkg::OP_W_CHK: begin
          if (nxt_rd == Head) begin
            prev_q <= Head;
          end else if (acc_q[cur_slot]) begin
            acc_q[cur_slot] <= 1'b0;
            prev_q          <= nxt_rd;
          end else if (dirty_q[cur_slot]) begin
            dirty_q[cur_slot] <= 1'b0;
            prev_q            <= nxt_rd;
          end else begin
            slot_q <= cur_slot;
          end
        end
        ecpr_pkg::OP_EVICT: begin
          used_q[slot_q]  <= 1'b0;
          acc_q[slot_q]   <= 1'b0;
          dirty_q[slot_q] <= 1'b0;
          count_q         <= count_q - 1'b1;
          hand_q          <= prev_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.action    = item_q.action;
    stat_o.reinsert  = item_q.reinsert;
    stat_o.hit       = hit;
    stat_o.scan_last = (scan_q == LastSlot);
    stat_o.full      = (count_q >= Head);
    stat_o.empty     = (count_q == '0);
    stat_o.cur_head  = (nxt_rd == Head);
    stat_o.cur_clean = !acc_q[cur_slot] && !dirty_q[cur_slot];
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

### hdl/enhanced_clock_page_replacer.sv
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacer
// Enhanced second-chance clock replacer over a ring of resident pages.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// command   in   start high, busy low      item_i   (action, page, write, reinsert)
// result    out  done_o, one cycle only    result_o (status, victim page)
//
// A map or reference scans the tag store one slot at a time, a read state
// then a compare state per slot; a victim walks the ring one step at a time,
// a read state then a check state per step, clearing accessed marks, then
// dirty marks, then evicting, so at most 2*NUM_FRAMES + 4 steps. The single
// read port of each link store sets the step time.
// Reset clears marks, count, head links and hand at once; no clearing pass.
// The result shows in the first cycle with busy low; the receiver cannot
// stall it, and a new item may be started in that same cycle.
// ----------------------------------------------------------------------------
module enhanced_clock_page_replacer #(
  parameter int unsigned NUM_FRAMES = ecpr_pkg::NumFramesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ecpr_pkg::item_t   item_i,
  output ecpr_pkg::result_t result_o,
  output logic              done_o
);

  ecpr_pkg::dp_cmd_t  cmd;
  ecpr_pkg::dp_stat_t stat;

  // sequencer
  ecpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // stores, ring links and result register
  ecpr_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

### hdl/ecpr_checker.sv
// ----------------------------------------------------------------------------
// ecpr_checker
// Port-level checks of the replacer, bound to the top level.
// ----------------------------------------------------------------------------
module ecpr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input ecpr_pkg::result_t result_o,
  input logic              done_o
);

  // an accepted item always keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item accepted but not busy");

  // a result is never shown while an item is still in work
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  // one result per item: no two strobes back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("repeated result");

  // failed actions never report a victim page
  a_fail_novictim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != ecpr_pkg::STAT_DONE |-> result_o.victim_page == '0)
    else $error("victim page on failed action");

endmodule

bind enhanced_clock_page_replacer ecpr_checker u_ecpr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .result_o (result_o),
  .done_o   (done_o)
);

### test/ecpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_scoreboard
// Watches the command and result channels of the clock page replacer, keeps
// its own copy of the page ring and marks, and checks every result in order.
// ----------------------------------------------------------------------------
module ecpr_scoreboard #(
  parameter int unsigned NUM_FRAMES = ecpr_pkg::NumFramesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  ecpr_pkg::item_t   item_i,
  input  ecpr_pkg::result_t result_i,
  input  logic              done_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                evictions_o,
  output int                full_hits_o,
  output int                misses_o
);
  import ecpr_pkg::*;

  localparam int Head = NUM_FRAMES;

  logic [PageBits-1:0] tag_q  [NUM_FRAMES];
  logic                acc_q  [NUM_FRAMES];
  logic                dirty_q[NUM_FRAMES];
  logic                used_q [NUM_FRAMES];
  int                  nxt_q  [NUM_FRAMES+1];
  int                  prv_q  [NUM_FRAMES+1];
  int                  hand_q;
  int                  resident_q;

  result_t expected_results[$];

  function automatic int find_page(logic [PageBits-1:0] pg);
    for (int s = 0; s < NUM_FRAMES; s++) begin
      if (used_q[s] && tag_q[s] == pg) return s;
    end
    return NUM_FRAMES;
  endfunction

  function automatic void unlink(int s);
    int p;
    int n;
    p = prv_q[s];
    n = nxt_q[s];
    nxt_q[p] = n;
    prv_q[n] = p;
    if (hand_q == s) hand_q = p;
  endfunction

  function automatic void link_tail(int s);
    int last;
    last = prv_q[Head];
    nxt_q[last] = s;
    prv_q[s]    = last;
    nxt_q[s]    = Head;
    prv_q[Head] = s;
  endfunction

  // one command in, one result out
  function automatic result_t predict_replacer(item_t it);
    result_t r;
    int s;
    int prev;
    int cur;
    r = '0;
    case (action_e'(it.action))
      ACT_MAP: begin
        s = find_page(it.page_number);
        if (s < NUM_FRAMES) begin
          if (it.reinsert) begin
            unlink(s);
            link_tail(s);
          end
        end else if (resident_q >= NUM_FRAMES) begin
          r.status = STAT_FULL;
        end else begin
          s = 0;
          while (s < NUM_FRAMES && used_q[s]) s++;
          tag_q[s]   = it.page_number;
          acc_q[s]   = 1'b0;
          dirty_q[s] = 1'b0;
          used_q[s]  = 1'b1;
          resident_q++;
          link_tail(s);
        end
      end
      ACT_REF: begin
        s = find_page(it.page_number);
        if (s < NUM_FRAMES) begin
          acc_q[s] = 1'b1;
          if (it.is_write) dirty_q[s] = 1'b1;
        end else begin
          r.status = STAT_MISS;
        end
      end
      ACT_VICTIM: begin
        if (resident_q == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          prev = hand_q;
          cur  = Head;
          // second chance: accessed first, then dirty, then evict
          for (int g = 0; g < 3 * NUM_FRAMES + 3; g++) begin
            cur = nxt_q[prev];
            if (cur == Head) begin
              prev = Head;
              cur  = nxt_q[Head];
            end
            if (acc_q[cur]) acc_q[cur] = 1'b0;
            else if (dirty_q[cur]) dirty_q[cur] = 1'b0;
            else break;
            prev = cur;
          end
          r.victim_page = tag_q[cur];
          unlink(cur);
          used_q[cur]  = 1'b0;
          acc_q[cur]   = 1'b0;
          dirty_q[cur] = 1'b0;
          resident_q--;
          hand_q = prev;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_FRAMES; s++) begin
        acc_q[s]   = 1'b0;
        dirty_q[s] = 1'b0;
        used_q[s]  = 1'b0;
      end
      nxt_q[Head] = Head;
      prv_q[Head] = Head;
      hand_q      = Head;
      resident_q  = 0;
      expected_results.delete();
      fail_count_o = 0;
      evictions_o  = 0;
      full_hits_o  = 0;
      misses_o     = 0;
    end else begin
      // results first: an item taken on this edge answers later
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d page %05h",
                 result_i.status, result_i.victim_page);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_i.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, result_i.status);
            fail_count_o++;
          end
          if (result_i.victim_page !== exp_r.victim_page) begin
            $error("victim_page: expected %05h, got %05h",
                   exp_r.victim_page, result_i.victim_page);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        exp_r = predict_replacer(item_i);
        expected_results.push_back(exp_r);
        if (action_e'(item_i.action) == ACT_VICTIM && exp_r.status == STAT_DONE)
          evictions_o++;
        if (exp_r.status == STAT_FULL) full_hits_o++;
        if (exp_r.status == STAT_MISS) misses_o++;
      end
    end
    pending_o = expected_results.size();
  end

endmodule

### test/tb_enhanced_clock_page_replacer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_enhanced_clock_page_replacer
// Drives map, reference, victim and reserved commands at the replacer with random
// gaps; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_enhanced_clock_page_replacer;
  import ecpr_pkg::*;

  localparam int NFrames   = NumFramesDef;
  localparam int PoolSize  = 96;
  localparam int NumRandom = 1100;
  // worst item is a victim walk of about two sweeps plus the longest random gap
  localparam int StallLimit = 5000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  result_t result_o;
  logic    done_o;

  int fail_count;
  int pending;
  int evictions;
  int full_hits;
  int misses;
  int stall_cycles = 0;
  int sent = 0;
  bit no_gaps = 1'b0;     // stretches of back to back commands

  logic [PageBits-1:0] page_pool[PoolSize];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  enhanced_clock_page_replacer #(.NUM_FRAMES(NFrames)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .result_o(result_o),
    .done_o  (done_o)
  );

  ecpr_scoreboard #(.NUM_FRAMES(NFrames)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item_i),
    .result_i    (result_o),
    .done_i      (done_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .evictions_o (evictions),
    .full_hits_o (full_hits),
    .misses_o    (misses)
  );

  // watchdog: counts edges on which neither channel moves
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_enhanced_clock_page_replacer NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one command: optional idle gap, then hold start until busy is low
  task automatic issue_cmd(action_e act, logic [PageBits-1:0] pg, logic wr, logic reins);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{action: act, page_number: pg, is_write: wr, reinsert: reins};
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  function automatic logic [PageBits-1:0] pick_page();
    // mostly the pool so hits are common, sometimes anything at all
    if ($urandom_range(0, 9) == 0) return PageBits'($urandom);
    return page_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  initial begin
    int mode;
    int roll;
    action_e act;

    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) page_pool[i] = PageBits'($urandom);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, misses, extremes, reinsert, marks, reserved code
    issue_cmd(ACT_VICTIM, 20'h12345, 1'b1, 1'b1);
    issue_cmd(ACT_REF,    20'h00000, 1'b1, 1'b0);
    issue_cmd(ACT_RSVD,   20'hFFFFF, 1'b1, 1'b1);
    issue_cmd(ACT_MAP,    20'h00000, 1'b0, 1'b0);
    issue_cmd(ACT_MAP,    20'hFFFFF, 1'b1, 1'b0);
    issue_cmd(ACT_MAP,    20'hA5A5A, 1'b0, 1'b0);
    issue_cmd(ACT_MAP,    20'h5A5A5, 1'b0, 1'b0);
    issue_cmd(ACT_MAP,    20'hFFFFF, 1'b0, 1'b0);  // resident, left alone
    issue_cmd(ACT_REF,    20'h00000, 1'b0, 1'b0);  // accessed only
    issue_cmd(ACT_REF,    20'hFFFFF, 1'b1, 1'b0);  // accessed and dirty
    issue_cmd(ACT_REF,    20'h11111, 1'b0, 1'b0);  // not resident
    issue_cmd(ACT_VICTIM, 20'h00000, 1'b0, 1'b0);  // skips marked pages
    issue_cmd(ACT_MAP,    20'h00000, 1'b0, 1'b1);  // moved to the tail
    issue_cmd(ACT_VICTIM, 20'hFFFFF, 1'b0, 1'b0);  // hand now on a page
    issue_cmd(ACT_MAP,    20'hFFFFF, 1'b0, 1'b1);  // reinsert under the hand
    issue_cmd(ACT_REF,    20'h5A5A5, 1'b1, 1'b0);
    issue_cmd(ACT_VICTIM, 20'h00000, 1'b0, 1'b0);
    issue_cmd(ACT_VICTIM, 20'h00000, 1'b0, 1'b0);
    issue_cmd(ACT_VICTIM, 20'h00000, 1'b0, 1'b0);
    issue_cmd(ACT_VICTIM, 20'h00000, 1'b0, 1'b0);  // drains to empty
    issue_cmd(ACT_MAP,    20'h5A5A5, 1'b0, 1'b1);  // reinsert of a new page

    // random: phases, picked at random, fill the ring to full, churn it or drain it
    mode = 0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 90 == 0) begin
        mode    = $urandom_range(0, 2);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (n == NumRandom / 2) begin
        start <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end
      roll = $urandom_range(0, 99);
      case (mode)
        0:       act = roll < 75 ? ACT_MAP : (roll < 95 ? ACT_REF : ACT_VICTIM);
        1:       act = roll < 35 ? ACT_MAP : (roll < 75 ? ACT_REF : ACT_VICTIM);
        default: act = roll < 20 ? ACT_MAP : (roll < 50 ? ACT_REF : ACT_VICTIM);
      endcase
      if ($urandom_range(0, 49) == 0) act = ACT_RSVD;
      issue_cmd(act, pick_page(), 1'($urandom), 1'($urandom));
    end

    start <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d commands: %0d evictions, %0d full-ring maps, %0d misses.",
             sent, evictions, full_hits, misses);
    if (fail_count == 0) begin
      $display("tb_enhanced_clock_page_replacer OK");
    end else begin
      $display("tb_enhanced_clock_page_replacer NOT OK");
    end
    $finish;
  end

endmodule
